[rtl/pic_pkg.sv]
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and constants for the priority interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

	localparam int unsigned NumLines = 8;
	localparam int unsigned LineW    = $clog2(NumLines);

	localparam logic [7:0] BaseMask  = 8'hf8;
	localparam logic [7:0] NoVector  = 8'hff;
	localparam logic [7:0] Icw1Flag  = 8'h10;
	localparam logic [7:0] MaskReset = 8'hff;

	typedef enum logic [2:0] {
		CMD_RAISE = 3'd0,
		CMD_ACK   = 3'd1,
		CMD_EOI   = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		PHASE_RUN  = 2'd0,
		PHASE_ICW2 = 2'd1,
		PHASE_ICW3 = 2'd2,
		PHASE_ICW4 = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0]       command;
		logic [LineW-1:0] line;
		logic             address_bit;
		logic [7:0]       write_data;
	} item_t;

	typedef struct packed {
		logic       interrupt_out;
		logic [7:0] vector;
		logic       vector_from_slave;
		logic [7:0] read_data;
		logic       read_valid;
	} result_t;

	typedef struct packed {
		logic             found;
		logic             in_service;
		logic [LineW-1:0] idx;
	} scan_t;

endpackage

[rtl/pic_if.sv]
// ----------------------------------------------------------------------------
// pic_if
// Command and result channels of the interrupt controller.
// ----------------------------------------------------------------------------
interface pic_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [2:0] line;
	logic       address_bit;
	logic [7:0] write_data;

	modport source (output valid, command, line, address_bit, write_data, input ready);
	modport sink   (input valid, command, line, address_bit, write_data, output ready);
endinterface

interface pic_res_if;
	logic       valid;
	logic       ready;
	logic       interrupt_out;
	logic [7:0] vector;
	logic       vector_from_slave;
	logic [7:0] read_data;
	logic       read_valid;

	modport source (output valid, interrupt_out, vector, vector_from_slave, read_data,
		read_valid, input ready);
	modport sink   (input valid, interrupt_out, vector, vector_from_slave, read_data,
		read_valid, output ready);
endinterface

[rtl/pic_scan.sv]
// ----------------------------------------------------------------------------
// pic_scan
// Priority scan: first line from 0 upward that is in service or is
// requested and unmasked.
// ----------------------------------------------------------------------------
module pic_scan (
	input  logic [pic_pkg::NumLines-1:0] request_bits,
	input  logic [pic_pkg::NumLines-1:0] mask_bits,
	input  logic [pic_pkg::NumLines-1:0] service_bits,
	output pic_pkg::scan_t               scan
);

	logic [pic_pkg::NumLines-1:0] hit;

	assign hit = service_bits | (request_bits & ~mask_bits);

	always_comb begin
		scan = '0;
		for (int i = pic_pkg::NumLines - 1; i >= 0; i--) begin
			if (hit[i]) begin
				scan.found      = 1'b1;
				scan.in_service = service_bits[i];
				scan.idx        = pic_pkg::LineW'(i);
			end
		end
	end

endmodule

[rtl/pic_core.sv]
// ----------------------------------------------------------------------------
// pic_core
// Controller state and the per-command update; produces one result per beat.
// ----------------------------------------------------------------------------
module pic_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  pic_pkg::item_t   item,
	input  logic             is_master,
	output pic_pkg::result_t result
);

	localparam int unsigned N = pic_pkg::NumLines;

	logic [N-1:0]           request_q, service_q, mask_q;
	logic [7:0]             icw1_q, icw2_q, icw3_q, icw4_q;
	pic_pkg::phase_t        phase_q;
	logic [N-1:0]           chosen_bit_q;
	logic [7:0]             chosen_vec_q;
	logic                   chosen_slave_q;
	logic                   pending_q;

	logic [N-1:0]           request_d, service_d, mask_d;
	logic [7:0]             icw1_d, icw2_d, icw3_d, icw4_d;
	pic_pkg::phase_t        phase_d;
	logic [N-1:0]           chosen_bit_d;
	logic [7:0]             chosen_vec_d;
	logic                   chosen_slave_d;
	logic                   pending_d;

	logic [N-1:0]           line_bit;
	logic [N-1:0]           raise_req;
	logic                   slave_line;
	pic_pkg::scan_t         scan;
	pic_pkg::phase_t        after_cascade;

	assign line_bit      = N'(1) << item.line;
	assign raise_req     = request_q | line_bit;
	assign slave_line    = is_master & icw3_q[scan.idx];
	assign after_cascade = icw1_q[0] ? pic_pkg::PHASE_ICW4 : pic_pkg::PHASE_RUN;

	pic_scan u_scan (
		.request_bits (raise_req),
		.mask_bits    (mask_q),
		.service_bits (service_q),
		.scan         (scan)
	);

	always_comb begin
		request_d      = request_q;
		service_d      = service_q;
		mask_d         = mask_q;
		icw1_d         = icw1_q;
		icw2_d         = icw2_q;
		icw3_d         = icw3_q;
		icw4_d         = icw4_q;
		phase_d        = phase_q;
		chosen_bit_d   = chosen_bit_q;
		chosen_vec_d   = chosen_vec_q;
		chosen_slave_d = chosen_slave_q;
		pending_d      = pending_q;
		result         = '0;

		unique case (item.command)
			pic_pkg::CMD_RAISE: begin
				request_d = raise_req;
				if ((line_bit & ~mask_q & ~service_q) != '0 && scan.found) begin
					if (scan.in_service) begin
						pending_d = 1'b0;
					end else begin
						chosen_bit_d   = N'(1) << scan.idx;
						chosen_slave_d = slave_line;
						chosen_vec_d   = slave_line ? pic_pkg::NoVector
							: ((icw2_q & pic_pkg::BaseMask) | 8'(scan.idx));
						pending_d      = 1'b1;
					end
				end
			end
			pic_pkg::CMD_ACK: begin
				service_d                = service_q | chosen_bit_q;
				pending_d                = 1'b0;
				result.vector            = chosen_vec_q;
				result.vector_from_slave = chosen_slave_q;
			end
			pic_pkg::CMD_EOI: begin
				service_d = service_q & ~chosen_bit_q;
				request_d = request_q & ~chosen_bit_q;
			end
			pic_pkg::CMD_WRITE: begin
				if (item.address_bit) begin
					unique case (phase_q)
						pic_pkg::PHASE_RUN: mask_d = item.write_data;
						pic_pkg::PHASE_ICW2: begin
							icw2_d = item.write_data;
							if (icw1_q[1]) begin
								icw3_d  = '0;
								phase_d = after_cascade;
							end else begin
								phase_d = pic_pkg::PHASE_ICW3;
							end
						end
						pic_pkg::PHASE_ICW3: begin
							icw3_d  = item.write_data;
							phase_d = after_cascade;
						end
						pic_pkg::PHASE_ICW4: begin
							icw4_d  = item.write_data;
							phase_d = pic_pkg::PHASE_RUN;
						end
					endcase
				end else if ((item.write_data & pic_pkg::Icw1Flag) != '0) begin
					icw1_d  = item.write_data;
					phase_d = pic_pkg::PHASE_ICW2;
				end
			end
			pic_pkg::CMD_READ: begin
				if (item.address_bit && phase_q == pic_pkg::PHASE_RUN) begin
					result.read_data  = mask_q;
					result.read_valid = 1'b1;
				end
			end
			default: ;
		endcase

		result.interrupt_out = pending_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_q      <= '0;
			service_q      <= '0;
			mask_q         <= pic_pkg::MaskReset;
			icw1_q         <= '0;
			icw2_q         <= '0;
			icw3_q         <= '0;
			icw4_q         <= '0;
			phase_q        <= pic_pkg::PHASE_RUN;
			chosen_bit_q   <= '0;
			chosen_vec_q   <= '0;
			chosen_slave_q <= 1'b0;
			pending_q      <= 1'b0;
		end else if (en) begin
			request_q      <= request_d;
			service_q      <= service_d;
			mask_q         <= mask_d;
			icw1_q         <= icw1_d;
			icw2_q         <= icw2_d;
			icw3_q         <= icw3_d;
			icw4_q         <= icw4_d;
			phase_q        <= phase_d;
			chosen_bit_q   <= chosen_bit_d;
			chosen_vec_q   <= chosen_vec_d;
			chosen_slave_q <= chosen_slave_d;
			pending_q      <= pending_d;
		end
	end

endmodule

[rtl/priority_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// priority_interrupt_controller
// Eight-line priority interrupt controller with ICW initialisation sequence.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | beat
//  cmd      | in  | valid/ready      | command, line, address_bit, write_data
//  res      | out | valid/ready      | interrupt_out, vector, vector_from_slave,
//           |     |                  | read_data, read_valid
//  cfg      | in  | cfg_we           | cfg_wdata -> is_master
//
//  One beat per cycle sustained while res.ready stays high; a command passes through
//  the input register, then state update and result register.
//  Reset clears all state; mask resets to all ones.
//  A stalled result holds the input stage; both stages fill before cmd.ready drops.
module priority_interrupt_controller (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	pic_cmd_if.sink      cmd,
	pic_res_if.source    res
);

	logic              is_master_q;
	logic              valid_s1;
	pic_pkg::item_t    item_s1;
	logic              valid_s2;
	pic_pkg::result_t  res_s2;
	pic_pkg::result_t  result;
	logic              adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_master_q <= 1'b0;
		end else if (cfg_we) begin
			is_master_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
			item_s1  <= '{command: cmd.command, line: cmd.line,
				address_bit: cmd.address_bit, write_data: cmd.write_data};
		end
	end

	pic_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv_s1),
		.item      (item_s1),
		.is_master (is_master_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			res_s2   <= '0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= valid_s1;
			res_s2   <= result;
		end
	end

	assign res.valid             = valid_s2;
	assign res.interrupt_out     = res_s2.interrupt_out;
	assign res.vector            = res_s2.vector;
	assign res.vector_from_slave = res_s2.vector_from_slave;
	assign res.read_data         = res_s2.read_data;
	assign res.read_valid        = res_s2.read_valid;

endmodule

[sim/pic_response_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pic_response_checker
// Tracks the controller state from every accepted command beat, predicts the
// result beat it produces, and compares result beats in order, field by field.
// ----------------------------------------------------------------------------
module pic_response_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	pic_cmd_if          cmd,
	pic_res_if          res,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	import pic_pkg::*;

	logic       is_master;
	logic [7:0] req_bits;
	logic [7:0] svc_bits;
	logic [7:0] mask_bits;
	logic [7:0] icw1;
	logic [7:0] icw2;
	logic [7:0] icw3;
	phase_t     phase;
	logic [7:0] chosen_bit;
	logic [7:0] chosen_vec;
	logic       chosen_slave;
	logic       irq_pending;

	item_t   beat;
	result_t want;
	result_t seen;
	result_t awaited_responses[$];

	function automatic void raise_line(input logic [LineW-1:0] ln);
		logic [7:0] hit;
		logic       done;
		int         i;
		hit = 8'd1 << ln;
		req_bits = req_bits | hit;
		done = 1'b0;
		if ((hit & ~mask_bits & ~svc_bits) != 8'd0) begin
			for (i = 0; i < NumLines; i++) begin
				if (!done && svc_bits[i]) begin
					irq_pending = 1'b0;
					done = 1'b1;
				end else if (!done && req_bits[i] && !mask_bits[i]) begin
					chosen_bit = 8'd1 << i;
					if (is_master && icw3[i]) begin
						chosen_slave = 1'b1;
						chosen_vec = NoVector;
					end else begin
						chosen_slave = 1'b0;
						chosen_vec = (icw2 & BaseMask) + 8'(i);
					end
					irq_pending = 1'b1;
					done = 1'b1;
				end
			end
		end
	endfunction

	function automatic void bus_write(input logic data_port, input logic [7:0] d);
		if (data_port) begin
			case (phase)
				PHASE_RUN: mask_bits = d;
				PHASE_ICW2: begin
					icw2 = d;
					// bit 1: single mode, bit 0: ICW4 follows
					if (icw1[1]) begin
						icw3 = 8'd0;
						phase = icw1[0] ? PHASE_ICW4 : PHASE_RUN;
					end else begin
						phase = PHASE_ICW3;
					end
				end
				PHASE_ICW3: begin
					icw3 = d;
					phase = icw1[0] ? PHASE_ICW4 : PHASE_RUN;
				end
				default: phase = PHASE_RUN;
			endcase
		end else if ((d & Icw1Flag) != 8'd0) begin
			icw1 = d;
			phase = PHASE_ICW2;
		end
	endfunction

	function automatic result_t next_response(input item_t cb);
		result_t r;
		r = '0;
		case (cb.command)
			CMD_RAISE: raise_line(cb.line);
			CMD_ACK: begin
				svc_bits = svc_bits | chosen_bit;
				irq_pending = 1'b0;
				r.vector = chosen_vec;
				r.vector_from_slave = chosen_slave;
			end
			CMD_EOI: begin
				svc_bits = svc_bits & ~chosen_bit;
				req_bits = req_bits & ~chosen_bit;
			end
			CMD_WRITE: bus_write(cb.address_bit, cb.write_data);
			CMD_READ: begin
				if (cb.address_bit && phase == PHASE_RUN) begin
					r.read_data = mask_bits;
					r.read_valid = 1'b1;
				end
			end
			default: ;
		endcase
		r.interrupt_out = irq_pending;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_master = 1'b0;
			req_bits = 8'd0;
			svc_bits = 8'd0;
			mask_bits = MaskReset;
			icw1 = 8'd0;
			icw2 = 8'd0;
			icw3 = 8'd0;
			phase = PHASE_RUN;
			chosen_bit = 8'd0;
			chosen_vec = 8'd0;
			chosen_slave = 1'b0;
			irq_pending = 1'b0;
			awaited_responses.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				is_master = cfg_wdata;
			end
			if (cmd.valid && cmd.ready) begin
				beat.command = cmd.command;
				beat.line = cmd.line;
				beat.address_bit = cmd.address_bit;
				beat.write_data = cmd.write_data;
				awaited_responses.push_back(next_response(beat));
			end
			if (res.valid && res.ready) begin
				seen.interrupt_out = res.interrupt_out;
				seen.vector = res.vector;
				seen.vector_from_slave = res.vector_from_slave;
				seen.read_data = res.read_data;
				seen.read_valid = res.read_valid;
				if (awaited_responses.size() == 0) begin
					$display("%0t: result beat with none awaited, expected nothing, got %h",
						$time, seen);
					fail_count++;
				end else begin
					want = awaited_responses.pop_front();
					check_field("interrupt_out", 8'(want.interrupt_out), 8'(seen.interrupt_out));
					check_field("vector", want.vector, seen.vector);
					check_field("vector_from_slave", 8'(want.vector_from_slave),
						8'(seen.vector_from_slave));
					check_field("read_data", want.read_data, seen.read_data);
					check_field("read_valid", 8'(want.read_valid), 8'(seen.read_valid));
				end
			end
			outstanding = awaited_responses.size();
		end
	end

endmodule

[sim/priority_interrupt_controller_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_interrupt_controller_tb
// Drives the interrupt controller with a directed opening (reads, masking,
// ICW sequences, nesting, cascade vectors) and then random phases of well
// formed init and interrupt cycles mixed with noise, under random back
// pressure on both channels and both cascade settings.
// ----------------------------------------------------------------------------
module priority_interrupt_controller_tb;
	import pic_pkg::*;

	localparam int unsigned CycleLimit  = 600000;
	localparam int unsigned RandomBeats = 900;
	localparam int unsigned DrainCycles = 8;
	localparam logic        PortCmd     = 1'b0;
	localparam logic        PortData    = 1'b1;
	localparam logic [2:0]  CmdSpare    = 3'd5;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        steady;
	int unsigned beats_sent;
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned outstanding;

	pic_cmd_if cmd_if ();
	pic_res_if res_if ();

	priority_interrupt_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_if),
		.res       (res_if)
	);

	pic_response_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd_if),
		.res         (res_if),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] mask_pattern();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4) begin
			return 8'h00;
		end else if (roll < 7) begin
			return 8'($urandom_range(0, 255));
		end else if (roll < 9) begin
			return 8'($urandom_range(0, 255)) | 8'($urandom_range(0, 255));
		end
		return MaskReset;
	endfunction

	task automatic issue(input logic [2:0] command, input logic [2:0] line, input logic port,
		input logic [7:0] data);
		int unsigned gap;
		cmd_if.valid       <= 1'b1;
		cmd_if.command     <= command;
		cmd_if.line        <= line;
		cmd_if.address_bit <= port;
		cmd_if.write_data  <= data;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		beats_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap != 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic issue_cmd(input logic [2:0] command);
		issue(command, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic raise_irq(input logic [2:0] line);
		issue(CMD_RAISE, line, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	task automatic write_port(input logic port, input logic [7:0] data);
		issue(CMD_WRITE, 3'($urandom_range(0, 7)), port, data);
	endtask

	task automatic read_port(input logic port);
		issue(CMD_READ, 3'($urandom_range(0, 7)), port, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic set_master(input logic master);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= master;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic init_sequence(input logic broken);
		logic [7:0] icw1;
		icw1 = 8'($urandom_range(0, 255)) | Icw1Flag;
		write_port(PortCmd, icw1);
		if (broken) begin
			read_port(PortData);
		end
		write_port(PortData, 8'($urandom_range(0, 255)));
		if (!icw1[1]) begin
			write_port(PortData, 8'($urandom_range(0, 255)));
		end
		if (icw1[0] && !(broken && $urandom_range(0, 1) == 1)) begin
			write_port(PortData, 8'($urandom_range(0, 255)));
		end
	endtask

	// ack is always followed by eoi so no line is left stuck in service
	task automatic interrupt_cycle();
		int unsigned n;
		n = $urandom_range(1, 3);
		repeat (n) raise_irq(3'($urandom_range(0, 7)));
		issue_cmd(CMD_ACK);
		if ($urandom_range(0, 3) == 0) begin
			raise_irq(3'd7);
		end
		if ($urandom_range(0, 9) == 0) begin
			read_port(PortData);
		end
		issue_cmd(CMD_EOI);
	endtask

	task automatic noise_beat();
		logic [2:0] code;
		code = 3'($urandom_range(0, 7));
		issue_cmd(code);
		if (code == CMD_ACK) begin
			issue_cmd(CMD_EOI);
		end
	endtask

	task automatic random_episode();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			init_sequence(pick < 3);
		end else if (pick < 24) begin
			write_port(PortData, mask_pattern());
		end else if (pick < 64) begin
			interrupt_cycle();
		end else begin
			noise_beat();
		end
	endtask

	initial begin
		int unsigned run;
		int unsigned stall;
		res_if.ready <= 1'b0;
		@(negedge clk);
		forever begin
			run = $urandom_range(1, 16);
			if ($urandom_range(0, 9) == 0) begin
				run = $urandom_range(50, 200);
			end
			res_if.ready <= 1'b1;
			repeat (run) @(negedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned phase_no;
		int unsigned target;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= 1'b0;
		cmd_if.valid       <= 1'b0;
		cmd_if.command     <= CMD_RAISE;
		cmd_if.line        <= 3'd0;
		cmd_if.address_bit <= PortCmd;
		cmd_if.write_data  <= 8'd0;
		steady = 1'b0;
		beats_sent = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_master(1'b0);

		read_port(PortData);
		read_port(PortCmd);
		raise_irq(3'd0);
		issue_cmd(CMD_ACK);
		issue_cmd(CMD_EOI);
		write_port(PortCmd, 8'h11);
		read_port(PortData);
		write_port(PortData, 8'hff);
		write_port(PortData, 8'h80);
		write_port(PortData, 8'h01);
		write_port(PortData, 8'h00);
		raise_irq(3'd7);
		issue_cmd(CMD_ACK);
		raise_irq(3'd7);
		issue_cmd(CMD_EOI);
		raise_irq(3'd3);
		issue_cmd(CMD_ACK);
		raise_irq(3'd5);
		issue_cmd(CMD_EOI);
		issue_cmd(CmdSpare);
		set_master(1'b1);
		raise_irq(3'd7);
		issue_cmd(CMD_ACK);
		issue_cmd(CMD_EOI);
		write_port(PortCmd, 8'h12);
		write_port(PortData, 8'h08);
		raise_irq(3'd7);
		issue_cmd(CMD_ACK);
		issue_cmd(CMD_EOI);

		target = beats_sent;
		for (phase_no = 0; phase_no < 4; phase_no++) begin
			set_master(!phase_no[0]);
			steady = (phase_no == 2);
			target = target + RandomBeats / 4;
			while (beats_sent < target) random_episode();
		end
		steady = 1'b0;

		// preemption by a higher priority line leaves the lower one in service
		write_port(PortCmd, 8'h12);
		write_port(PortData, 8'h40);
		write_port(PortData, 8'h00);
		raise_irq(3'd6);
		issue_cmd(CMD_ACK);
		raise_irq(3'd2);
		issue_cmd(CMD_ACK);
		issue_cmd(CMD_EOI);
		read_port(PortData);

		wait_idle();
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
